FILE: hw/rtl/pnsm_pkg.sv
package pnsm_pkg;

  localparam int AMP_W  = 25;
  localparam int CFG_W  = 25;
  localparam int HG_W   = 16;
  localparam int GAIN_W = 23;
  localparam int VS_W   = 17;
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 40;
  localparam int VEL_W  = 7;
  localparam int PH_W   = 32;

  localparam logic [AMP_W-1:0] AMP_FULL = 25'd16777216;
  localparam longint Q30 = 64'sd1073741824;

  localparam logic [16:0] SEMI_Q16 [12] = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2,
    OP_TICK     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_ATTACK   = 2'd0,
    REG_RELEASE  = 2'd1,
    REG_HARMONIC = 2'd2,
    REG_MIN_VEL  = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COUNT,
    ST_GAIN,
    ST_READ,
    ST_ENV,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_ACC,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic [VEL_W-1:0] velocity;
    logic [PH_W-1:0]  phase;
    logic [AMP_W-1:0] amplitude;
  } voice_t;

  localparam int VOICE_W = $bits(voice_t);

  // quarter-wave sine in q1.15, polynomial in q30
  function automatic int quarter_sine(int u, int bits);
    longint t;
    longint p;
    longint s;
    longint y;
    t = longint'(u) <<< (32 - bits);
    p = t * t / Q30;
    s = 64'sd172272;
    s = -64'sd5026991 + s * p / Q30;
    s = 64'sd85569306 + s * p / Q30;
    s = -64'sd693598669 + s * p / Q30;
    s = 64'sd1686629713 + s * p / Q30;
    y = s * t / Q30;
    if (y < 0) y = 0;
    y = (y + 16384) / 32768;
    if (y > 32767) y = 32767;
    return int'(y);
  endfunction

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned x;
    longint unsigned r;
    longint unsigned b;
    x = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/polyphonic_note_synth_mixer.sv
// note events are handled while idle; a tick's sample is built in order by a count pass,
// a gain step, a voice pass that runs each sounding voice through a shared multiplier and
// clears each voice that releases out, and a mix step; with no active voice the pass is skipped
// the next request can be taken once the sample is registered; note events give no sample
// the mix cycle holds while a finished sample waits in a stalled output register
// synchronous active-low reset clears all voices and loads the default envelope settings
module polyphonic_note_synth_mixer import pnsm_pkg::*; #(
  parameter int VOICE_COUNT     = 128,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_RATE_HZ  = 16000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [6:0]         in_note_number,
  input  logic [6:0]         in_velocity,
  input  logic signed [15:0] in_speech_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_codec_sample,
  output logic signed [15:0] out_amp_sample
);

  localparam int VW = VOICE_COUNT > 1 ? $clog2(VOICE_COUNT) : 1;
  localparam int CW = $clog2(VOICE_COUNT + 1);
  localparam logic [VW-1:0] LAST = VW'(VOICE_COUNT - 1);

  state_t state_r, state_nxt;

  logic [AMP_W-1:0] attack_r, attack_nxt;
  logic [AMP_W-1:0] release_r, release_nxt;
  logic [HG_W-1:0]  harm_r, harm_nxt;
  logic [HG_W-1:0]  minv_r, minv_nxt;

  logic [VOICE_COUNT-1:0] active_r, active_nxt;
  logic [VOICE_COUNT-1:0] rel_r, rel_nxt;

  logic [VW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic signed [15:0] speech_r, speech_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [AMP_W-1:0]   amp_r, amp_nxt;
  logic [PH_W-1:0]    phase_r, phase_nxt;
  logic [VEL_W-1:0]   vel_r, vel_nxt;
  logic [VS_W-1:0]    vs_r, vs_nxt;
  logic signed [15:0] s1_r, s1_nxt;
  logic signed [15:0] s2_r, s2_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] codec_r, codec_nxt;
  logic signed [15:0] ampo_r, ampo_nxt;

  logic              in_acc;
  logic              key_ok;
  logic [VW-1:0]     key;
  logic              last;
  logic              drop;
  logic              out_free;

  logic              ram_we;
  logic [VW-1:0]     ram_waddr;
  voice_t            ram_wdata;
  voice_t            rd;

  logic signed [15:0] t_sin1, t_sin2;
  logic [PH_W-1:0]    t_step;
  logic [GAIN_W-1:0]  t_gain;
  logic [VS_W-1:0]    t_vs;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic [AMP_W:0]          att_sum;
  logic [AMP_W-1:0]        env_amp;
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] q256, q128;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign key_ok   = ({1'b0, in_note_number} < 8'(VOICE_COUNT));
  assign key      = in_note_number[VW-1:0];
  assign last     = (idx_r == LAST);
  assign drop     = rel_r[idx_r] && (rd.amplitude <= release_r);
  assign out_free = !out_valid_r || !out_stall;

  pnsm_ram #(
    .WIDTH(VOICE_W),
    .DEPTH(VOICE_COUNT)
  ) u_voice_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r),
    .rdata(rd)
  );

  pnsm_tables #(
    .VOICE_COUNT    (VOICE_COUNT),
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
  ) u_tables (
    .phase   (rd.phase),
    .voice   (idx_r),
    .count   (cnt_r),
    .velocity(rd.velocity),
    .sin1    (t_sin1),
    .sin2    (t_sin2),
    .step    (t_step),
    .gain    (t_gain),
    .vscale  (t_vs)
  );

  // envelope step on the voice just read
  always_comb begin
    att_sum = {1'b0, rd.amplitude} + {1'b0, attack_r};
    if (rel_r[idx_r]) begin
      env_amp = rd.amplitude - release_r;
    end else if (rd.amplitude < AMP_FULL) begin
      env_amp = (att_sum > {1'b0, AMP_FULL}) ? AMP_FULL : att_sum[AMP_W-1:0];
    end else begin
      env_amp = rd.amplitude;
    end
  end

  // shared multiplier
  always_comb begin
    case (state_r)
      ST_MUL1: begin
        mul_a = MUL_W'(s2_r);
        mul_b = MUL_W'($signed({1'b0, harm_r}));
      end
      ST_MUL2: begin
        mul_a = MUL_W'(s1_r) + MUL_W'(prod_r >>> 15);
        mul_b = MUL_W'($signed({1'b0, amp_r}));
      end
      ST_MUL3: begin
        mul_a = MUL_W'(prod_r >>> 24);
        mul_b = MUL_W'($signed({1'b0, vs_r}));
      end
      ST_MUL4: begin
        mul_a = MUL_W'(prod_r >>> 15);
        mul_b = MUL_W'($signed({1'b0, gain_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // mix with truncation toward zero
  always_comb begin
    total = (SUM_W'(speech_r) <<< 8) + sum_r;
    q256  = (total + (total < 0 ? SUM_W'(255) : SUM_W'(0))) >>> 8;
    q128  = (total + (total < 0 ? SUM_W'(127) : SUM_W'(0))) >>> 7;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && in_opcode == OP_TICK) state_nxt = ST_COUNT;
      ST_COUNT: if (last) state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = (cnt_r == '0) ? ST_MIX : ST_READ;
      ST_READ: begin
        if (active_r[idx_r]) state_nxt = ST_ENV;
        else if (last) state_nxt = ST_MIX;
      end
      ST_ENV: begin
        if (!drop) state_nxt = ST_MUL1;
        else state_nxt = last ? ST_MIX : ST_READ;
      end
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_MUL3;
      ST_MUL3:  state_nxt = ST_MUL4;
      ST_MUL4:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last ? ST_MIX : ST_READ;
      ST_MIX:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    attack_nxt    = attack_r;
    release_nxt   = release_r;
    harm_nxt      = harm_r;
    minv_nxt      = minv_r;
    active_nxt    = active_r;
    rel_nxt       = rel_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    gain_nxt      = gain_r;
    speech_nxt    = speech_r;
    sum_nxt       = sum_r;
    amp_nxt       = amp_r;
    phase_nxt     = phase_r;
    vel_nxt       = vel_r;
    vs_nxt        = vs_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    prod_nxt      = prod_r;
    codec_nxt     = codec_r;
    ampo_nxt      = ampo_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = '{velocity: vel_r, phase: phase_r + t_step, amplitude: amp_r};

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK:   attack_nxt  = cfg_data;
        REG_RELEASE:  release_nxt = cfg_data;
        REG_HARMONIC: harm_nxt    = cfg_data[HG_W-1:0];
        REG_MIN_VEL:  minv_nxt    = cfg_data[HG_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_opcode)
            OP_NOTE_ON, OP_NOTE_OFF: begin
              if (key_ok) begin
                if (in_opcode == OP_NOTE_ON && in_velocity != '0) begin
                  active_nxt[key] = 1'b1;
                  rel_nxt[key]    = 1'b0;
                  ram_we          = 1'b1;
                  ram_waddr       = key;
                  ram_wdata       = '{velocity: in_velocity, phase: '0, amplitude: '0};
                end else if (active_r[key]) begin
                  rel_nxt[key] = 1'b1;
                end
              end
            end
            OP_ALL_OFF: begin
              active_nxt = '0;
              rel_nxt    = '0;
            end
            OP_TICK: begin
              idx_nxt    = '0;
              cnt_nxt    = '0;
              speech_nxt = in_speech_sample;
            end
            default: ;
          endcase
        end
      end
      ST_COUNT: begin
        cnt_nxt = cnt_r + CW'(active_r[idx_r]);
        if (!last) idx_nxt = idx_r + 1'b1;
      end
      ST_GAIN: begin
        gain_nxt = t_gain;
        sum_nxt  = '0;
        idx_nxt  = '0;
      end
      ST_READ: begin
        if (!active_r[idx_r] && !last) idx_nxt = idx_r + 1'b1;
      end
      ST_ENV: begin
        if (drop) begin
          // released out: counted for the gain but silent
          active_nxt[idx_r] = 1'b0;
          rel_nxt[idx_r]    = 1'b0;
          if (!last) idx_nxt = idx_r + 1'b1;
        end else begin
          amp_nxt   = env_amp;
          phase_nxt = rd.phase;
          vel_nxt   = rd.velocity;
          vs_nxt    = (t_vs < {1'b0, minv_r}) ? {1'b0, minv_r} : t_vs;
          s1_nxt    = t_sin1;
          s2_nxt    = t_sin2;
        end
      end
      ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4: begin
        prod_nxt = mul_p;
      end
      ST_ACC: begin
        sum_nxt = sum_r + SUM_W'(prod_r >>> 15);
        ram_we  = 1'b1;
        if (!last) idx_nxt = idx_r + 1'b1;
      end
      ST_MIX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          codec_nxt = (q256 > 32767) ? 16'sh7fff : (q256 < -32768) ? -16'sh8000 : 16'(q256);
          ampo_nxt  = (q128 > 32767) ? 16'sh7fff : (q128 < -32768) ? -16'sh8000 : 16'(q128);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      attack_r    <= 25'd524288;
      release_r   <= 25'd17476;
      harm_r      <= 16'd11469;
      minv_r      <= 16'd21299;
      active_r    <= '0;
      rel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      attack_r    <= attack_nxt;
      release_r   <= release_nxt;
      harm_r      <= harm_nxt;
      minv_r      <= minv_nxt;
      active_r    <= active_nxt;
      rel_r       <= rel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    gain_r   <= gain_nxt;
    speech_r <= speech_nxt;
    sum_r    <= sum_nxt;
    amp_r    <= amp_nxt;
    phase_r  <= phase_nxt;
    vel_r    <= vel_nxt;
    vs_r     <= vs_nxt;
    s1_r     <= s1_nxt;
    s2_r     <= s2_nxt;
    prod_r   <= prod_nxt;
    codec_r  <= codec_nxt;
    ampo_r   <= ampo_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_codec_sample = codec_r;
  assign out_amp_sample   = ampo_r;

endmodule

FILE: hw/rtl/pnsm_ram.sv
module pnsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/pnsm_tables.sv
module pnsm_tables import pnsm_pkg::*; #(
  parameter int VOICE_COUNT     = 128,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_RATE_HZ  = 16000
) (
  input  logic [PH_W-1:0]                        phase,
  input  logic [(VOICE_COUNT > 1 ? $clog2(VOICE_COUNT) : 1)-1:0] voice,
  input  logic [$clog2(VOICE_COUNT+1)-1:0]       count,
  input  logic [VEL_W-1:0]                       velocity,
  output logic signed [15:0]                     sin1,
  output logic signed [15:0]                     sin2,
  output logic [PH_W-1:0]                        step,
  output logic [GAIN_W-1:0]                      gain,
  output logic [VS_W-1:0]                        vscale
);

  localparam int B       = SINE_TABLE_BITS;
  localparam int QUARTER = 1 << (B - 2);

  logic [14:0]       qtab  [QUARTER+1];
  logic [PH_W-1:0]   steps [VOICE_COUNT];
  logic [GAIN_W-1:0] gains [VOICE_COUNT+1];
  logic [VS_W-1:0]   vst   [1 << VEL_W];
  logic [B-1:0]      sidx  [2];
  logic signed [15:0] sval [2];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_qsin
    localparam logic [14:0] V = 15'(quarter_sine(g, B));
    assign qtab[g] = V;
  end

  for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_step
    localparam int M = g + 3;
    localparam longint unsigned X = longint'(440) * longint'(SEMI_Q16[M % 12]);
    localparam longint unsigned NUM = X << (M / 12 + 10);
    localparam logic [PH_W-1:0] S = 32'((NUM + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ);
    assign steps[g] = S;
  end

  for (genvar g = 0; g <= VOICE_COUNT; g++) begin : g_gain
    localparam longint unsigned Q = 64'd16777216000000 / (g == 0 ? 1 : g);
    localparam logic [GAIN_W-1:0] G = (g == 0) ? '0 : GAIN_W'(isqrt64(Q));
    assign gains[g] = G;
  end

  for (genvar g = 0; g < (1 << VEL_W); g++) begin : g_vs
    localparam logic [VS_W-1:0] V = VS_W'((g * 32768 + 63) / 127);
    assign vst[g] = V;
  end

  assign sidx[0] = phase[PH_W-1 -: B];
  assign sidx[1] = phase[PH_W-2 -: B];

  // quarter mirror on odd quadrants, negate in the second half of the period
  for (genvar k = 0; k < 2; k++) begin : g_look
    logic [B-3:0] r;
    logic [B-2:0] ti;
    logic [14:0]  mag;
    assign r   = sidx[k][B-3:0];
    assign ti  = sidx[k][B-2] ? ((B-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
    assign mag = qtab[ti];
    assign sval[k] = sidx[k][B-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign sin1   = sval[0];
  assign sin2   = sval[1];
  assign step   = steps[voice];
  assign gain   = gains[count];
  assign vscale = vst[velocity];

endmodule
